>>> rtl/assert_macros.svh
// assertion helpers included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every clock edge out of reset
`define MT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication: when cond holds, expr holds in the same cycle
`define MT_ASSERT_IMPL(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define MT_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> rtl/mt_pkg.sv
package mt_pkg;

  // default sizing
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // field widths of the items
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IN_VAL_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FIELD_W = 5;
  localparam int unsigned FIELD_MAX = 31;

  // command codes, code three acts as count
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [IN_VAL_W-1:0] value;
  } mt_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] occurrences;
    logic [FIELD_W-1:0] bag_size;
    logic               is_empty;
  } mt_out_t;

  // control part of the token that walks the cell row
  typedef struct packed {
    logic             vld;
    logic [CMD_W-1:0] cmd;
    logic             done;
  } mt_ctl_t;

endpackage

>>> rtl/mt_cell.sv
module mt_cell
  import mt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned OCC_W      = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mt_ctl_t               tok_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [OCC_W-1:0]      occ_i,
  output mt_ctl_t               tok_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [OCC_W-1:0]      occ_o
);

  logic                  slot_vld_q, slot_vld_d;
  logic [VALUE_BITS-1:0] slot_val_q, slot_val_d;
  mt_ctl_t               tok_q, tok_d;
  logic [VALUE_BITS-1:0] val_q;
  logic [OCC_W-1:0]      occ_q, occ_d;
  logic                  hit, take, clr, post_match;

  // slot compare and the action of this cell on the passing token
  always_comb begin
    hit        = slot_vld_q && (slot_val_q == value_i);
    take       = tok_i.vld && (tok_i.cmd == CMD_ADD) && !tok_i.done && !slot_vld_q;
    clr        = tok_i.vld && (tok_i.cmd == CMD_REMOVE) && !tok_i.done && hit;
    post_match = take || (hit && !clr);
    slot_vld_d = (slot_vld_q || take) && !clr;
    slot_val_d = take ? value_i : slot_val_q;
    tok_d      = tok_i;
    tok_d.done = tok_i.done || take || clr;
    occ_d      = occ_i + OCC_W'(post_match);
  end

  // slot valid mark and token valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
      tok_q      <= '0;
    end else begin
      slot_vld_q <= slot_vld_d;
      tok_q      <= tok_d;
    end
  end

  // stored value and token payload
  always_ff @(posedge clk_i) begin
    slot_val_q <= slot_val_d;
    val_q      <= value_i;
    occ_q      <= occ_d;
  end

  assign tok_o   = tok_q;
  assign value_o = val_q;
  assign occ_o   = occ_q;

endmodule

>>> rtl/multiset_table_top.sv
// Bounded multiset of values held in a row of CAPACITY cells, one slot per
// cell. A command (add, remove, count) enters the first cell and walks the
// row one cell per clock: the first free cell takes an add, the first
// matching cell clears on a remove, and each cell adds its post-command
// match to a running copy count. One item is in the row at a time: the
// next item is accepted only after the token has left the last cell, and
// the result is registered in the output register. A result waiting to be
// taken does not block the next item; a second finished result is held in a
// skid register, and the input stalls while that register is full.
module multiset_table_top
  import mt_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  mt_in_t  in_item_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output mt_out_t out_item_o
);

`include "assert_macros.svh"

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
  localparam int unsigned SAT_W = (OCC_W > FIELD_W) ? OCC_W : FIELD_W;

  mt_ctl_t               tok_w [CAPACITY+1];
  logic [VALUE_BITS-1:0] val_w [CAPACITY+1];
  logic [OCC_W-1:0]      occ_w [CAPACITY+1];

  logic             busy_q, busy_d;
  logic [OCC_W-1:0] cnt_q, cnt_d;
  logic             out_vld_q, out_vld_d;
  mt_out_t          out_q, out_d;
  logic             hold_vld_q, hold_vld_d;
  mt_out_t          hold_q, hold_d;
  logic             accept, fin, add_done, rem_done;
  mt_out_t          res;
  logic [SAT_W-1:0] occ_ext, cnt_ext;

  assign in_stall_o = busy_q || hold_vld_q;
  assign accept     = in_valid_i && !in_stall_o;

  // token entering the first cell
  assign tok_w[0] = '{vld: accept, cmd: in_item_i.command, done: 1'b0};
  assign val_w[0] = VALUE_BITS'(in_item_i.value);
  assign occ_w[0] = '0;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mt_cell #(
      .VALUE_BITS(VALUE_BITS),
      .OCC_W     (OCC_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_w[i]),
      .value_i(val_w[i]),
      .occ_i  (occ_w[i]),
      .tok_o  (tok_w[i+1]),
      .value_o(val_w[i+1]),
      .occ_o  (occ_w[i+1])
    );
  end

  // result from the token leaving the last cell
  always_comb begin
    fin      = tok_w[CAPACITY].vld;
    add_done = fin && (tok_w[CAPACITY].cmd == CMD_ADD) && tok_w[CAPACITY].done;
    rem_done = fin && (tok_w[CAPACITY].cmd == CMD_REMOVE) && tok_w[CAPACITY].done;
    cnt_d    = cnt_q + OCC_W'(add_done) - OCC_W'(rem_done);
    occ_ext  = SAT_W'(occ_w[CAPACITY]);
    cnt_ext  = SAT_W'(cnt_d);
    case (tok_w[CAPACITY].cmd)
      CMD_ADD:    res.status = tok_w[CAPACITY].done ? STAT_OK : STAT_FULL;
      CMD_REMOVE: res.status = tok_w[CAPACITY].done ? STAT_OK : STAT_NOT_FOUND;
      default:    res.status = (occ_w[CAPACITY] != '0) ? STAT_OK : STAT_NOT_FOUND;
    endcase
    res.occurrences = (occ_ext > SAT_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX)
                                                    : occ_ext[FIELD_W-1:0];
    res.bag_size    = (cnt_ext > SAT_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX)
                                                    : cnt_ext[FIELD_W-1:0];
    res.is_empty    = (cnt_d == '0);
  end

  // busy flag, output register and skid register
  always_comb begin
    busy_d     = busy_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = hold_vld_q;
      out_d     = hold_q;
      hold_vld_d = 1'b0;
    end
    if (fin) begin
      busy_d = 1'b0;
      if (!out_vld_q || !out_stall_i) begin
        out_vld_d = 1'b1;
        out_d     = res;
      end else begin
        hold_vld_d = 1'b1;
        hold_d     = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // checks
  `MT_ASSERT(a_cnt_range, cnt_q <= OCC_W'(CAPACITY), "element count above capacity")
  `MT_ASSERT_IMPL(a_hold_order, hold_vld_q, out_vld_q, "skid full while output empty")
  `MT_ASSERT_IMPL(a_fin_busy, fin, busy_q && !accept, "token left row while idle")
  `MT_ASSERT_NEXT(a_accept_busy, accept, busy_q, "accepted item not tracked as busy")

endmodule
